// ===== sv/hpc_pkg.sv =====
// shared types, constants and helpers of the homogeneous polygon clipper
package hpc_pkg;

    localparam int MAX_IN_VERTS_DEF = 16;
    localparam int FRAC_BITS_DEF    = 16;
    localparam int NUM_PLANES       = 6;
    localparam int VWORDS           = 13;
    localparam int WORD_W           = 32;
    localparam int DATA_W           = VWORDS * WORD_W;
    localparam int DIST_W           = 35;
    localparam int MIN_VERTS        = 3;
    localparam int NRM_BASE         = 10;

    typedef logic [VWORDS-1:0][WORD_W-1:0] vert_t;
    typedef logic signed [DIST_W-1:0] dist_t;

    typedef enum logic [2:0] {
        PL_NEAR, PL_FAR, PL_LEFT, PL_RIGHT, PL_TOP, PL_BOTTOM
    } plane_t;

    typedef struct packed {
        logic  close;
        logic  rej;
        vert_t v;
    } msg_t;

    typedef enum logic [3:0] {
        X_IDLE, X_DIV, X_MUL, X_ADD, X_SQ, X_SQA, X_SQRT, X_NINIT, X_NSTEP, X_NWR, X_DONE
    } xstate_t;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_CUR, S_XSTART, S_XWAIT, S_XOUT, S_CLOSE
    } cstate_t;

    typedef enum logic [1:0] {
        T_COLLECT, T_FETCH, T_SEND
    } tstate_t;

    function automatic dist_t plane_dist(plane_t pl, vert_t v);
        dist_t x, y, z, w, d;
        x = dist_t'(signed'(v[0]));
        y = dist_t'(signed'(v[1]));
        z = dist_t'(signed'(v[2]));
        w = dist_t'(signed'(v[3]));
        case (pl)
            PL_NEAR:   d = z;
            PL_FAR:    d = w - z;
            PL_LEFT:   d = x + w;
            PL_RIGHT:  d = w - x;
            PL_TOP:    d = w - y;
            PL_BOTTOM: d = w + y;
            default:   d = '0;
        endcase
        return d;
    endfunction

    // packed 64-bit fields carry the first component in the high word
    function automatic int slot_of(int i);
        return (i >= 4 && i <= 11) ? (i ^ 1) : i;
    endfunction

    function automatic vert_t unpack_vert(logic [DATA_W-1:0] d);
        vert_t v;
        for (int i = 0; i < VWORDS; i++) begin
            v[i] = d[slot_of(i)*WORD_W +: WORD_W];
        end
        return v;
    endfunction

    function automatic logic [DATA_W-1:0] pack_vert(vert_t v);
        logic [DATA_W-1:0] d;
        for (int i = 0; i < VWORDS; i++) begin
            d[slot_of(i)*WORD_W +: WORD_W] = v[i];
        end
        return d;
    endfunction

endpackage

// ===== sv/hpc_cross.sv =====
// edge crossing unit: iterative divide, interpolation and normal renormalization
module hpc_cross import hpc_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  start,
    input  vert_t vin,
    input  dist_t din,
    input  vert_t vout,
    input  dist_t dout,
    output logic  done,
    output vert_t vres
);

    localparam int RW         = DIST_W + 1;
    localparam int PW         = WORD_W + 2 + FRAC_BITS;
    localparam int SQRT_STEPS = 32;
    localparam int CNTW       = $clog2(SQRT_STEPS);
    localparam int IW         = $clog2(VWORDS);
    localparam int LW         = WORD_W + 1;
    localparam int NRW        = WORD_W + 2;
    localparam logic signed [PW-1:0] HALF = PW'(64'sd1 << (FRAC_BITS - 1));

    xstate_t state_reg, state_next;

    vert_t                 vin_reg, vout_reg, res_reg;
    logic [RW-1:0]         den_reg, rem_reg;
    logic [FRAC_BITS-1:0]  t_reg;
    logic signed [PW-1:0]  prod_reg;
    logic [63:0]           sq_reg, s_reg, root_reg, sbit_reg;
    logic [NRW-1:0]        nrem_reg;
    logic [FRAC_BITS:0]    q_reg;
    logic [CNTW-1:0]       cnt_reg;
    logic [IW-1:0]         idx_reg;
    logic [1:0]            nidx_reg;

    dist_t                 den_c;
    logic [RW-1:0]         rem2;
    logic                  div_ge;
    logic signed [WORD_W:0] diff;
    logic signed [PW-1:0]  rsum, rshift;
    logic [IW-1:0]         nw;
    logic [WORD_W-1:0]     nval, mag, qw;
    logic [63:0]           root_add;
    logic [LW-1:0]         len;
    logic [NRW-1:0]        nrem2;
    logic                  n_ge, n0_ge;
    logic                  last_f, last_sq;

    assign den_c    = din - dout;
    assign rem2     = {rem_reg[RW-2:0], 1'b0};
    assign div_ge   = rem2 >= den_reg;
    assign diff     = (WORD_W+1)'(signed'(vout_reg[idx_reg]))
                    - (WORD_W+1)'(signed'(vin_reg[idx_reg]));
    assign rsum     = prod_reg + HALF;
    assign rshift   = rsum >>> FRAC_BITS;
    assign nw       = IW'(NRM_BASE) + IW'(nidx_reg);
    assign nval     = res_reg[nw];
    assign mag      = nval[WORD_W-1] ? (WORD_W'(0) - nval) : nval;
    assign root_add = root_reg + sbit_reg;
    assign len      = root_reg[LW-1:0];
    assign n0_ge    = {1'b0, mag} >= len;
    assign nrem2    = {nrem_reg[NRW-2:0], 1'b0};
    assign n_ge     = nrem2 >= NRW'(len);
    assign qw       = WORD_W'(q_reg);
    assign last_f   = cnt_reg == CNTW'(FRAC_BITS - 1);
    assign last_sq  = cnt_reg == CNTW'(SQRT_STEPS - 1);

    assign done = state_reg == X_DONE;
    assign vres = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= X_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            X_IDLE:  if (start) state_next = X_DIV;
            X_DIV:   if (last_f) state_next = X_MUL;
            X_MUL:   state_next = X_ADD;
            X_ADD:   state_next = (idx_reg == IW'(VWORDS - 1)) ? X_SQ : X_MUL;
            X_SQ:    state_next = X_SQA;
            X_SQA:   state_next = (nidx_reg == 2'd2) ? X_SQRT : X_SQ;
            X_SQRT: begin
                if (last_sq) begin
                    // zero-length normal is left as interpolated
                    state_next = (root_reg[63:2] == '0 && (root_reg[1:0] == 2'd0)
                                  && !(s_reg >= root_add)) ? X_DONE : X_NINIT;
                end
            end
            X_NINIT: state_next = X_NSTEP;
            X_NSTEP: if (last_f) state_next = X_NWR;
            X_NWR:   state_next = (nidx_reg == 2'd2) ? X_DONE : X_NINIT;
            X_DONE:  state_next = X_IDLE;
            default: state_next = X_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            X_IDLE: begin
                if (start) begin
                    vin_reg  <= vin;
                    vout_reg <= vout;
                    den_reg  <= RW'(unsigned'(den_c));
                    rem_reg  <= RW'(unsigned'(din));
                    t_reg    <= '0;
                    cnt_reg  <= '0;
                end
            end
            X_DIV: begin
                rem_reg <= div_ge ? (rem2 - den_reg) : rem2;
                t_reg   <= {t_reg[FRAC_BITS-2:0], div_ge};
                cnt_reg <= cnt_reg + CNTW'(1);
                idx_reg <= '0;
            end
            X_MUL: begin
                prod_reg <= PW'(diff) * PW'(signed'({1'b0, t_reg}));
            end
            X_ADD: begin
                res_reg[idx_reg] <= vin_reg[idx_reg] + rshift[WORD_W-1:0];
                idx_reg  <= idx_reg + IW'(1);
                nidx_reg <= '0;
                s_reg    <= '0;
            end
            X_SQ: begin
                sq_reg <= 64'(mag) * 64'(mag);
            end
            X_SQA: begin
                s_reg    <= s_reg + sq_reg;
                nidx_reg <= nidx_reg + 2'd1;
                root_reg <= '0;
                sbit_reg <= 64'd1 << 62;
                cnt_reg  <= '0;
            end
            X_SQRT: begin
                if (s_reg >= root_add) begin
                    s_reg    <= s_reg - root_add;
                    root_reg <= (root_reg >> 1) + sbit_reg;
                end else begin
                    root_reg <= root_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
                cnt_reg  <= cnt_reg + CNTW'(1);
                nidx_reg <= '0;
            end
            X_NINIT: begin
                nrem_reg <= n0_ge ? NRW'({1'b0, mag} - len) : NRW'(mag);
                q_reg    <= (FRAC_BITS+1)'(n0_ge);
                cnt_reg  <= '0;
            end
            X_NSTEP: begin
                nrem_reg <= n_ge ? (nrem2 - NRW'(len)) : nrem2;
                q_reg    <= {q_reg[FRAC_BITS-1:0], n_ge};
                cnt_reg  <= cnt_reg + CNTW'(1);
            end
            X_NWR: begin
                res_reg[nw] <= nval[WORD_W-1] ? (WORD_W'(0) - qw) : qw;
                nidx_reg    <= nidx_reg + 2'd1;
            end
            default: begin
            end
        endcase
    end

endmodule

// ===== sv/hpc_cell.sv =====
// one clip stage: keeps first and previous vertex, clips one edge per vertex
module hpc_cell import hpc_pkg::*; #(
    parameter plane_t PLANE        = PL_NEAR,
    parameter int     MAX_IN_VERTS = MAX_IN_VERTS_DEF,
    parameter int     FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  msg_t in_msg,
    output logic out_valid,
    input  logic out_ready,
    output msg_t out_msg
);

    localparam int MAX_OUT = MAX_IN_VERTS + NUM_PLANES;
    localparam int CW      = $clog2(MAX_OUT + 1);

    cstate_t state_reg, state_next;

    logic          has_first_reg, closing_reg, rej_reg;
    logic [CW-1:0] count_reg;
    vert_t         first_reg, cur_reg, nxt_reg;

    dist_t dc, dn;
    logic  cur_in, room, x_start, x_done, in_fire, out_fire;
    vert_t x_res;
    cstate_t end_state;

    assign dc        = plane_dist(PLANE, cur_reg);
    assign dn        = plane_dist(PLANE, nxt_reg);
    assign cur_in    = !dc[DIST_W-1];
    assign room      = count_reg < CW'(MAX_OUT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign end_state = closing_reg ? S_CLOSE : S_IDLE;

    hpc_cross #(.FRAC_BITS(FRAC_BITS)) u_cross (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (x_start),
        .vin     (cur_in ? cur_reg : nxt_reg),
        .din     (cur_in ? dc : dn),
        .vout    (cur_in ? nxt_reg : cur_reg),
        .dout    (cur_in ? dn : dc),
        .done    (x_done),
        .vres    (x_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        x_start    = 1'b0;
        out_msg    = '{close: 1'b0, rej: 1'b0, v: cur_reg};
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    if (in_msg.close) begin
                        state_next = has_first_reg ? S_DECIDE : S_CLOSE;
                    end else if (has_first_reg) begin
                        state_next = S_DECIDE;
                    end
                end
            end
            S_DECIDE: begin
                if (cur_in) begin
                    state_next = S_CUR;
                end else if (!dn[DIST_W-1]) begin
                    state_next = S_XSTART;
                end else begin
                    state_next = end_state;
                end
            end
            S_CUR: begin
                // past the vertex limit the stage drops what it would emit
                out_valid = room;
                if (!room || out_ready) begin
                    state_next = dn[DIST_W-1] ? S_XSTART : end_state;
                end
            end
            S_XSTART: begin
                x_start    = 1'b1;
                state_next = S_XWAIT;
            end
            S_XWAIT: begin
                if (x_done) state_next = S_XOUT;
            end
            S_XOUT: begin
                out_valid   = room;
                out_msg.v   = x_res;
                if (!room || out_ready) state_next = end_state;
            end
            S_CLOSE: begin
                out_valid     = 1'b1;
                out_msg.close = 1'b1;
                out_msg.rej   = rej_reg || (count_reg < CW'(MIN_VERTS));
                if (out_ready) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            has_first_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            if (in_fire && !in_msg.close && !has_first_reg) begin
                has_first_reg <= 1'b1;
            end
            if (out_fire) begin
                if (state_reg == S_CLOSE) begin
                    has_first_reg <= 1'b0;
                    count_reg     <= '0;
                end else begin
                    count_reg <= count_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            closing_reg <= in_msg.close;
            rej_reg     <= in_msg.rej;
            if (in_msg.close) begin
                cur_reg <= nxt_reg;
                nxt_reg <= first_reg;
            end else if (has_first_reg) begin
                cur_reg <= nxt_reg;
                nxt_reg <= in_msg.v;
            end else begin
                first_reg <= in_msg.v;
                nxt_reg   <= in_msg.v;
            end
        end
    end

endmodule

// ===== sv/homogeneous_polygon_clipper.sv =====
// polygon clipper top: input staging, chain of six clip stages, result buffer
// each stage takes a new vertex only after it has finished the previous one; an edge
//   that crosses a plane runs through that stage's iterative divide/sqrt unit
// results leave one at a time, each read from the buffer and then sent, after the
//   closing vertex clears all six stages
// reset: aresetn synchronous active low, clears state machines, valid flags and pointers; vertex stores stay undefined
module homogeneous_polygon_clipper import hpc_pkg::*; #(
    parameter int MAX_IN_VERTS = MAX_IN_VERTS_DEF,
    parameter int FRAC_BITS    = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    // view_x, view_y, view_z, view_w, world_xy, world_zw, tex_uv, normal_xy, normal_z
    input  logic [DATA_W-1:0] s_tdata,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    // out_view_x .. out_view_w, out_world_xy, out_world_zw, out_tex_uv,
    // out_normal_xy, out_normal_z
    output logic [DATA_W-1:0] m_tdata,
    output logic              m_tlast,
    // rejected
    output logic              m_tuser
);

    localparam int MAX_OUT = MAX_IN_VERTS + NUM_PLANES;
    localparam int CW      = $clog2(MAX_OUT + 1);
    localparam int AW      = $clog2(MAX_OUT);

    msg_t               ch_msg   [NUM_PLANES+1];
    logic [NUM_PLANES:0] ch_valid, ch_ready;

    logic  in_valid_reg, in_close_reg, close_pend_reg;
    vert_t in_v_reg;

    tstate_t       state_reg, state_next;
    logic [CW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic          rej_reg;
    vert_t         mem [MAX_OUT];
    vert_t         rd_data_reg;
    logic          sink_fire, send_last;

    assign s_tready    = !in_valid_reg;
    assign ch_valid[0] = in_valid_reg;
    assign ch_msg[0]   = '{close: in_close_reg, rej: 1'b0, v: in_v_reg};

    // a closing vertex goes in as the vertex itself, then a close marker
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            close_pend_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg   <= 1'b1;
            close_pend_reg <= s_tlast;
        end else if (ch_valid[0] && ch_ready[0]) begin
            if (close_pend_reg) begin
                close_pend_reg <= 1'b0;
            end else begin
                in_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_close_reg <= 1'b0;
            in_v_reg     <= unpack_vert(s_tdata);
        end else if (ch_valid[0] && ch_ready[0] && close_pend_reg) begin
            in_close_reg <= 1'b1;
        end
    end

    for (genvar k = 0; k < NUM_PLANES; k++) begin : g_stage
        hpc_cell #(
            .PLANE        (plane_t'(k)),
            .MAX_IN_VERTS (MAX_IN_VERTS),
            .FRAC_BITS    (FRAC_BITS)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (ch_valid[k]),
            .in_ready  (ch_ready[k]),
            .in_msg    (ch_msg[k]),
            .out_valid (ch_valid[k+1]),
            .out_ready (ch_ready[k+1]),
            .out_msg   (ch_msg[k+1])
        );
    end

    assign ch_ready[NUM_PLANES] = state_reg == T_COLLECT;
    assign sink_fire = ch_valid[NUM_PLANES] && ch_ready[NUM_PLANES];
    assign send_last = rej_reg || (rd_ptr_reg == wr_ptr_reg - CW'(1));

    assign m_tvalid = state_reg == T_SEND;
    assign m_tlast  = send_last;
    assign m_tuser  = rej_reg;
    assign m_tdata  = rej_reg ? '0 : pack_vert(rd_data_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_COLLECT;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            T_COLLECT: begin
                if (sink_fire && ch_msg[NUM_PLANES].close) begin
                    state_next = ch_msg[NUM_PLANES].rej ? T_SEND : T_FETCH;
                end
            end
            T_FETCH: state_next = T_SEND;
            T_SEND: begin
                if (m_tready) state_next = send_last ? T_COLLECT : T_FETCH;
            end
            default: state_next = T_COLLECT;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            rej_reg    <= 1'b0;
        end else begin
            case (state_reg)
                T_COLLECT: begin
                    if (sink_fire) begin
                        if (ch_msg[NUM_PLANES].close) begin
                            rej_reg    <= ch_msg[NUM_PLANES].rej;
                            rd_ptr_reg <= '0;
                        end else begin
                            wr_ptr_reg <= wr_ptr_reg + CW'(1);
                        end
                    end
                end
                T_SEND: begin
                    if (m_tready) begin
                        if (send_last) begin
                            wr_ptr_reg <= '0;
                        end else begin
                            rd_ptr_reg <= rd_ptr_reg + CW'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (sink_fire && !ch_msg[NUM_PLANES].close) begin
            mem[wr_ptr_reg[AW-1:0]] <= ch_msg[NUM_PLANES].v;
        end
        rd_data_reg <= mem[rd_ptr_reg[AW-1:0]];
    end

`ifndef NO_ASSERTIONS
    a_reject_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("rejected result not marked last");

    a_close_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        close_pend_reg |-> in_valid_reg)
        else $error("close marker pending without staged vertex");

    a_buffer_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        sink_fire && !ch_msg[NUM_PLANES].close |-> wr_ptr_reg < CW'(MAX_OUT))
        else $error("result buffer overrun");

    a_min_polygon: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> wr_ptr_reg >= CW'(MIN_VERTS))
        else $error("accepted polygon below three vertices");
`endif

endmodule
